@@ rtl/gsfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsfc_pkg
// Shared types, codes and helper functions for the sentence framer/checker.
// ----------------------------------------------------------------------------
package gsfc_pkg;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_HASH   = 8'h23;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;

	localparam logic [2:0] ST_NONE      = 3'd0;
	localparam logic [2:0] ST_NMEA_OK   = 3'd1;
	localparam logic [2:0] ST_CRC_OK    = 3'd2;
	localparam logic [2:0] ST_NMEA_BAD  = 3'd3;
	localparam logic [2:0] ST_CRC_BAD   = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	localparam logic [0:0] CFG_IDX_POLY    = 1'd0;
	localparam logic [0:0] CFG_IDX_MAX_LEN = 1'd1;

	localparam logic [31:0] POLY_RESET    = 32'hEDB88320;
	localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

	localparam logic [3:0] NMEA_DIGITS = 4'd2;
	localparam logic [3:0] CRC_DIGITS  = 4'd8;

	typedef struct packed {
		logic [31:0] crc_polynomial;
		logic [15:0] max_body_length;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        body_valid;
		logic [7:0]  body_byte;
		logic        sentence_begin;
		logic [31:0] computed_check;
	} result_t;

	// reflected byte-wise crc update, eight shift steps
	function automatic logic [31:0] crc_byte(
		input logic [31:0] crc,
		input logic [7:0]  b,
		input logic [31:0] poly
	);
		logic [31:0] t;
		t = {24'd0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			if (t[0]) begin
				t = (t >> 1) ^ poly;
			end else begin
				t = t >> 1;
			end
		end
		return {8'd0, crc[31:8]} ^ t;
	endfunction

	// ascii hex digit, either case; valid flag in the top bit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

@@ rtl/gnss_sentence_framer_checker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_sentence_framer_checker_core
// NMEA / CRC-32 ASCII framer/checker, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one received character per transaction and returns one result per
// character. Throughput is one character per clock while the output is not
// stalled. A taken character is held in the input register, and its result
// loads into the result register once that register is free; an output
// stall holds the character in the input register meanwhile. The crc update
// for a whole byte (eight reflected shift steps) sits between those two
// registers, so those eight chained steps set the critical path. The result
// register frees the input side whenever the consumer takes the pending
// result. Configuration writes are always ready and must only be issued
// while no character is in flight.
module gnss_sentence_framer_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        body_valid,
	output logic [7:0]  body_byte,
	output logic        sentence_begin,
	output logic [31:0] computed_check,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import gsfc_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_s2;
	logic    valid_s1, valid_s2;
	logic [7:0] byte_s1;
	logic    move_s2, fire, load_s1;

	assign cfg_ready = 1'b1;

	gsfc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign move_s2  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && move_s2;
	assign in_stall = valid_s1 && !move_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || move_s2) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= in_byte;
		end
	end

	gsfc_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = res_s2.status;
	assign body_valid     = res_s2.body_valid;
	assign body_byte      = res_s2.body_byte;
	assign sentence_begin = res_s2.sentence_begin;
	assign computed_check = res_s2.computed_check;

endmodule

@@ rtl/gsfc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsfc_cfg_regs
// Configuration register file: crc polynomial and body length limit.
// ----------------------------------------------------------------------------
module gsfc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [0:0]    wr_index,
	input  logic [31:0]   wr_data,
	output gsfc_pkg::cfg_t cfg
);
	import gsfc_pkg::*;

	logic [31:0] poly_q;
	logic [15:0] max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q    <= POLY_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_IDX_POLY:    poly_q    <= wr_data;
				CFG_IDX_MAX_LEN: max_len_q <= wr_data[15:0];
				default:         ;
			endcase
		end
	end

	assign cfg.crc_polynomial  = poly_q;
	assign cfg.max_body_length = max_len_q;

endmodule

@@ rtl/gsfc_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsfc_framer
// Sentence framing state, running checksums and per-byte result logic.
// ----------------------------------------------------------------------------
module gsfc_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        byte_in,
	input  gsfc_pkg::cfg_t    cfg,
	output gsfc_pkg::result_t res
);
	import gsfc_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic        kind_q, kind_d;
	logic [7:0]  xor_q, xor_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] rcv_q, rcv_d;
	logic [3:0]  dcnt_q, dcnt_d;
	logic [15:0] blen_q, blen_d;

	logic [31:0] cur_check;
	logic [4:0]  hex;
	logic [31:0] rcv_next;
	logic [3:0]  dcnt_next;
	logic [3:0]  need;
	logic        ok;

	assign cur_check = kind_q ? crc_q : {24'd0, xor_q};
	assign hex       = hex_value(byte_in);
	assign rcv_next  = {rcv_q[27:0], hex[3:0]};
	assign dcnt_next = dcnt_q + 4'd1;
	assign need      = kind_q ? CRC_DIGITS : NMEA_DIGITS;
	assign ok        = (rcv_next == cur_check);

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		xor_d   = xor_q;
		crc_d   = crc_q;
		rcv_d   = rcv_q;
		dcnt_d  = dcnt_q;
		blen_d  = blen_q;
		res     = '0;

		if (byte_in == CHAR_DOLLAR || byte_in == CHAR_HASH) begin
			// any start character restarts framing
			res.sentence_begin = 1'b1;
			kind_d  = (byte_in == CHAR_HASH);
			xor_d   = 8'd0;
			crc_d   = 32'd0;
			rcv_d   = 32'd0;
			dcnt_d  = 4'd0;
			blen_d  = 16'd0;
			phase_d = PH_BODY;
		end else begin
			case (phase_q)
				PH_BODY: begin
					if (byte_in == CHAR_STAR) begin
						phase_d = PH_DIGITS;
						dcnt_d  = 4'd0;
						rcv_d   = 32'd0;
					end else if (blen_q >= cfg.max_body_length) begin
						res.status         = ST_OVERFLOW;
						res.computed_check = cur_check;
						phase_d            = PH_IDLE;
					end else begin
						res.body_valid = 1'b1;
						res.body_byte  = byte_in;
						xor_d  = xor_q ^ byte_in;
						crc_d  = crc_byte(crc_q, byte_in, cfg.crc_polynomial);
						blen_d = blen_q + 16'd1;
					end
				end
				PH_DIGITS: begin
					if (!hex[4]) begin
						res.status         = kind_q ? ST_CRC_BAD : ST_NMEA_BAD;
						res.computed_check = cur_check;
						phase_d            = PH_IDLE;
					end else begin
						rcv_d  = rcv_next;
						dcnt_d = dcnt_next;
						if (dcnt_next >= need) begin
							if (kind_q) begin
								res.status = ok ? ST_CRC_OK : ST_CRC_BAD;
							end else begin
								res.status = ok ? ST_NMEA_OK : ST_NMEA_BAD;
							end
							res.computed_check = cur_check;
							phase_d            = PH_IDLE;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= 1'b0;
			xor_q   <= 8'd0;
			crc_q   <= 32'd0;
			rcv_q   <= 32'd0;
			dcnt_q  <= 4'd0;
			blen_q  <= 16'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			xor_q   <= xor_d;
			crc_q   <= crc_d;
			rcv_q   <= rcv_d;
			dcnt_q  <= dcnt_d;
			blen_q  <= blen_d;
		end
	end

endmodule
